// ----- sv/heat_diffusion_row_update_assert.svh -----
// assertion macros for the heat diffusion row update block
// expects aclk and aresetn in the scope of each use, no other dependencies
`ifndef HEAT_DIFFUSION_ROW_UPDATE_ASSERT_SVH
`define HEAT_DIFFUSION_ROW_UPDATE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define HDRU_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define HDRU_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- sv/hdru_pkg.sv -----
// shared constants and types for the heat diffusion row update block
// no dependencies; used by hdru_cell, hdru_mul and the top level
package hdru_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int INDEX_WIDTH         = 16;
    localparam int ENERGY_WIDTH        = 48;
    localparam int GAIN_WIDTH          = 16;
    localparam int WIDTH_REG_WIDTH     = 32;
    localparam int DIGIT_WIDTH         = 16;
    localparam int FACTOR_WIDTH        = 2 * DIGIT_WIDTH;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIFFUSION_GAIN = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOUNDARY_SCALE = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_WIDTH     = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_LENGTH     = 8'd3;

    localparam logic [GAIN_WIDTH-1:0]      RESET_DIFFUSION_GAIN = 16'd6554;
    localparam logic [GAIN_WIDTH-1:0]      RESET_BOUNDARY_SCALE = 16'd59578;
    localparam logic [WIDTH_REG_WIDTH-1:0] RESET_CELL_WIDTH     = 32'd6554;
    localparam logic [INDEX_WIDTH-1:0]     RESET_ROW_LENGTH     = 16'd1001;

    // shortest legal row, and its last position
    localparam logic [INDEX_WIDTH-1:0] MIN_ROW_LENGTH = 16'd3;
    localparam logic [INDEX_WIDTH-1:0] MIN_LAST_POS   = 16'd2;

    // half an lsb of a q.16 product, for round half away from zero
    localparam logic [DIGIT_WIDTH-1:0] ROUND_HALF = 16'h8000;

    typedef struct packed {
        logic start;
        logic two_digits;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// ----- sv/hdru_cell.sv -----
// one sample cell of the stencil window; hands its sample to the next cell
// uses hdru_pkg only for the default of its width parameter
module hdru_cell #(
    parameter int WIDTH = hdru_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    shift_en,
    input  logic signed [WIDTH-1:0] data_in,
    output logic signed [WIDTH-1:0] data_out
);

    logic signed [WIDTH-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= data_in;
        end
    end

    assign data_out = sample_reg;

endmodule

// ----- sv/hdru_mul.sv -----
// digit-serial magnitude multiplier with q.16 rounding, 16 factor bits a cycle
// uses hdru_pkg for digit width, rounding constant and control structs
module hdru_mul #(
    parameter int MAG_WIDTH = 50
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  hdru_pkg::mul_ctrl_t                             ctrl,
    input  logic [MAG_WIDTH-1:0]                            mag_in,
    input  logic [hdru_pkg::FACTOR_WIDTH-1:0]               factor_in,
    output hdru_pkg::mul_stat_t                             stat,
    output logic [MAG_WIDTH+hdru_pkg::DIGIT_WIDTH-1:0]      result
);

    localparam int DW        = hdru_pkg::DIGIT_WIDTH;
    localparam int FW        = hdru_pkg::FACTOR_WIDTH;
    localparam int PART_W    = MAG_WIDTH + DW;
    localparam int ACC_WIDTH = MAG_WIDTH + FW;

    logic [MAG_WIDTH-1:0] mag_reg;
    logic [FW-1:0]        fac_reg;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic                 more_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [PART_W-1:0]    part;
    logic [ACC_WIDTH-1:0] acc_next;
    logic [ACC_WIDTH-1:0] acc_round;

    // high digit first: acc = acc * 2^16 + mag * digit
    assign part     = PART_W'(mag_reg) * PART_W'(fac_reg[FW-1 -: DW]);
    assign acc_next = (acc_reg << DW) + ACC_WIDTH'(part);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && !more_reg) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mag_reg  <= mag_in;
            acc_reg  <= '0;
            more_reg <= ctrl.two_digits;
            fac_reg  <= ctrl.two_digits ? factor_in : {factor_in[DW-1:0], {DW{1'b0}}};
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            more_reg <= 1'b0;
            fac_reg  <= fac_reg << DW;
        end
    end

    assign acc_round = acc_reg + ACC_WIDTH'(hdru_pkg::ROUND_HALF);
    assign result    = acc_round[ACC_WIDTH-1:DW];

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- sv/heat_diffusion_row_update.sv -----
// top level of the heat diffusion row update block (1d ftcs stencil)
// uses hdru_pkg, hdru_cell, hdru_mul and heat_diffusion_row_update_assert.svh

// One time row of a 1d heat grid streams in as signed q16.16 samples in index
// order; the next row streams out, one beat per grid point, with its index.
// Interior point i becomes r[i] + gain*(r[i+1] - 2*r[i] + r[i-1]), the left
// point is the new point 1 times boundary_scale, the right point passes through
// unchanged, and the final beat of a row (tlast) also carries the row energy,
// the sum of the new values times cell_width. Products round half away from
// zero; values saturate to VALUE_WIDTH bits, the energy to 48 bits. Samples at
// positions 0 and 1 of a row produce nothing. Each later sample blocks the input
// until it is done: it passes the single shared serial multiplier once, twice at
// position 2 (which also yields the left boundary), and once more at the last
// position of the row for the energy. That multiplier takes one 16 bit factor
// digit per cycle, and a stalled output side holds the block as well.
// Configuration writes are accepted in any cycle and are meant for idle time.
module heat_diffusion_row_update #(
    parameter int VALUE_WIDTH = hdru_pkg::VALUE_WIDTH_DEFAULT,
    localparam int S_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_WIDTH =
        ((VALUE_WIDTH + hdru_pkg::INDEX_WIDTH + hdru_pkg::ENERGY_WIDTH + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [S_TDATA_WIDTH-1:0]             s_tdata,   // prev_value
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [M_TDATA_WIDTH-1:0]             m_tdata,   // new_value, point_index, row_energy
    output logic                                 m_tlast,   // last_of_row
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hdru_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int IW        = hdru_pkg::INDEX_WIDTH;
    localparam int EW        = hdru_pkg::ENERGY_WIDTH;
    localparam int GW        = hdru_pkg::GAIN_WIDTH;
    localparam int CW        = hdru_pkg::WIDTH_REG_WIDTH;
    localparam int FW        = hdru_pkg::FACTOR_WIDTH;
    localparam int LAP_WIDTH = VALUE_WIDTH + 2;
    localparam int MAG_WIDTH = (LAP_WIDTH > EW) ? LAP_WIDTH : EW;
    localparam int RES_WIDTH = MAG_WIDTH + hdru_pkg::DIGIT_WIDTH;
    localparam int UW        = RES_WIDTH + 2;
    localparam int NUM_CELLS = 2;

    // saturation bounds at the wide update width
    localparam logic signed [UW-1:0] VMAX_U =
        {{(UW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [UW-1:0] VMIN_U =
        {{(UW - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};
    localparam logic [EW-1:0] EMAX = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] EMIN = {1'b1, {(EW - 1){1'b0}}};
    localparam logic [RES_WIDTH-1:0] EMAX_R = {{(RES_WIDTH - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
    localparam logic [RES_WIDTH-1:0] ENEG_R =
        {{(RES_WIDTH - EW){1'b0}}, 1'b1, {(EW - 1){1'b0}}};

    typedef enum logic [10:0] {
        ST_IDLE        = 11'b000_0000_0001,
        ST_GAIN_GO     = 11'b000_0000_0010,
        ST_GAIN_WAIT   = 11'b000_0000_0100,
        ST_LEFT_GO     = 11'b000_0000_1000,
        ST_LEFT_WAIT   = 11'b000_0001_0000,
        ST_OUT_LEFT    = 11'b000_0010_0000,
        ST_OUT_UPD     = 11'b000_0100_0000,
        ST_SUM_LAST    = 11'b000_1000_0000,
        ST_ENERGY_GO   = 11'b001_0000_0000,
        ST_ENERGY_WAIT = 11'b010_0000_0000,
        ST_OUT_LAST    = 11'b100_0000_0000
    } state_t;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_value(input logic signed [UW-1:0] x);
        logic signed [VALUE_WIDTH-1:0] y;
        if (x > VMAX_U) begin
            y = VMAX_U[VALUE_WIDTH-1:0];
        end else if (x < VMIN_U) begin
            y = VMIN_U[VALUE_WIDTH-1:0];
        end else begin
            y = x[VALUE_WIDTH-1:0];
        end
        return y;
    endfunction

    state_t state_reg, state_next;

    // configuration registers
    logic [GW-1:0] diffusion_gain_reg;
    logic [GW-1:0] boundary_scale_reg;
    logic [CW-1:0] cell_width_reg;
    logic [IW-1:0] row_length_reg;

    // row bookkeeping
    logic [IW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic          last_reg;
    logic          at_left_reg;

    // datapath registers
    logic signed [LAP_WIDTH-1:0]   lap_reg;
    logic signed [VALUE_WIDTH-1:0] upd_reg, upd_next;
    logic signed [VALUE_WIDTH-1:0] left_reg, left_next;
    logic signed [EW-1:0]          energy_sum_reg;
    logic [EW-1:0]                 energy_reg, energy_next;

    // output register
    logic                          m_tvalid_reg;
    logic signed [VALUE_WIDTH-1:0] out_value_reg;
    logic [IW-1:0]                 out_index_reg;
    logic                          out_last_reg;
    logic [EW-1:0]                 out_energy_reg;

    logic                          accept;
    logic                          out_free;
    logic                          load_out;
    logic signed [VALUE_WIDTH-1:0] cur_sample;
    logic signed [VALUE_WIDTH-1:0] cell_data [NUM_CELLS];
    logic signed [VALUE_WIDTH-1:0] cell_in   [NUM_CELLS];
    logic [IW-1:0]                 last_pos;
    logic                          last_now;
    logic signed [LAP_WIDTH-1:0]   lap_now;

    // shared multiplier hookup
    hdru_pkg::mul_ctrl_t           mul_ctrl;
    hdru_pkg::mul_stat_t           mul_stat;
    logic [MAG_WIDTH-1:0]          mul_mag;
    logic [FW-1:0]                 mul_factor;
    logic [RES_WIDTH-1:0]          mul_result;
    logic                          mul_neg;
    logic signed [RES_WIDTH:0]     r_pos;
    logic signed [RES_WIDTH:0]     r_signed;

    logic [LAP_WIDTH-1:0]          lap_mag;
    logic [VALUE_WIDTH-1:0]        upd_mag;
    logic [EW-1:0]                 esum_mag;

    // energy accumulator input
    logic                          acc_en;
    logic signed [VALUE_WIDTH-1:0] acc_val;
    logic signed [EW:0]            acc_sum;
    logic signed [EW-1:0]          acc_sat;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cur_sample = s_tdata[VALUE_WIDTH-1:0];  // bits above the value are dropped

    // ---------------------------------------------------------------------
    // sample window: cell 0 holds the newest sample, cell 1 the one before
    // ---------------------------------------------------------------------
    assign cell_in[0] = cur_sample;
    assign cell_in[1] = cell_data[0];

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_window
        hdru_cell #(
            .WIDTH    (VALUE_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .data_in  (cell_in[g]),
            .data_out (cell_data[g])
        );
    end

    // laplacian taken as the sample arrives, before the window shifts
    assign lap_now = LAP_WIDTH'(cur_sample) - (LAP_WIDTH'(cell_data[0]) <<< 1)
                   + LAP_WIDTH'(cell_data[1]);

    // short rows behave as three points; a shrunk length ends the row at once
    assign last_pos = (row_length_reg < hdru_pkg::MIN_ROW_LENGTH) ?
                      hdru_pkg::MIN_LAST_POS : row_length_reg - 1'b1;
    assign last_now = (count_reg >= last_pos);

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diffusion_gain_reg <= hdru_pkg::RESET_DIFFUSION_GAIN;
            boundary_scale_reg <= hdru_pkg::RESET_BOUNDARY_SCALE;
            cell_width_reg     <= hdru_pkg::RESET_CELL_WIDTH;
            row_length_reg     <= hdru_pkg::RESET_ROW_LENGTH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hdru_pkg::REG_DIFFUSION_GAIN: diffusion_gain_reg <= cfg_data[GW-1:0];
                hdru_pkg::REG_BOUNDARY_SCALE: boundary_scale_reg <= cfg_data[GW-1:0];
                hdru_pkg::REG_CELL_WIDTH:     cell_width_reg     <= cfg_data[CW-1:0];
                hdru_pkg::REG_ROW_LENGTH:     row_length_reg     <= cfg_data[IW-1:0];
                default: begin
                    // unknown register index, write dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // multiplier operand selection and result signs
    // ---------------------------------------------------------------------
    assign lap_mag  = lap_reg[LAP_WIDTH-1] ? (LAP_WIDTH'(0) - lap_reg) : lap_reg;
    assign upd_mag  = upd_reg[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - upd_reg) : upd_reg;
    assign esum_mag = energy_sum_reg[EW-1] ? (EW'(0) - energy_sum_reg) : energy_sum_reg;

    always_comb begin
        mul_ctrl.start      = 1'b0;
        mul_ctrl.two_digits = 1'b0;
        mul_mag             = '0;
        mul_factor          = '0;
        case (state_reg)
            ST_GAIN_GO: begin
                mul_ctrl.start = 1'b1;
                mul_mag        = MAG_WIDTH'(lap_mag);
                mul_factor     = FW'(diffusion_gain_reg);
            end
            ST_LEFT_GO: begin
                mul_ctrl.start = 1'b1;
                mul_mag        = MAG_WIDTH'(upd_mag);
                mul_factor     = FW'(boundary_scale_reg);
            end
            ST_ENERGY_GO: begin
                mul_ctrl.start      = 1'b1;
                mul_ctrl.two_digits = 1'b1;
                mul_mag             = MAG_WIDTH'(esum_mag);
                mul_factor          = cell_width_reg;
            end
            default: begin
                mul_ctrl.start = 1'b0;
            end
        endcase
    end

    hdru_mul #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mul_ctrl),
        .mag_in    (mul_mag),
        .factor_in (mul_factor),
        .stat      (mul_stat),
        .result    (mul_result)
    );

    // sign of whatever is in the multiplier, read from its still-held source
    always_comb begin
        case (state_reg)
            ST_GAIN_WAIT:   mul_neg = lap_reg[LAP_WIDTH-1];
            ST_LEFT_WAIT:   mul_neg = upd_reg[VALUE_WIDTH-1];
            ST_ENERGY_WAIT: mul_neg = energy_sum_reg[EW-1];
            default:        mul_neg = 1'b0;
        endcase
    end

    assign r_pos    = signed'({1'b0, mul_result});
    assign r_signed = mul_neg ? -r_pos : r_pos;

    // interior update uses the centre sample, now in cell 1
    assign upd_next  = sat_value(UW'(cell_data[1]) + UW'(r_signed));
    assign left_next = sat_value(UW'(r_signed));

    always_comb begin
        if (mul_neg) begin
            energy_next = (mul_result > ENEG_R) ? EMIN : (EW'(0) - mul_result[EW-1:0]);
        end else begin
            energy_next = (mul_result > EMAX_R) ? EMAX : mul_result[EW-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // running energy sum, saturating, fed once per emitted point
    // ---------------------------------------------------------------------
    always_comb begin
        acc_en  = 1'b0;
        acc_val = cell_data[0];
        case (state_reg)
            ST_OUT_LEFT: begin
                acc_en  = out_free;
                acc_val = left_reg;
            end
            ST_OUT_UPD: begin
                acc_en  = out_free;
                acc_val = upd_reg;
            end
            ST_SUM_LAST: begin
                acc_en  = 1'b1;
                acc_val = cell_data[0];
            end
            default: begin
                acc_en = 1'b0;
            end
        endcase
    end

    assign acc_sum = (EW + 1)'(energy_sum_reg) + (EW + 1)'(acc_val);
    assign acc_sat = (acc_sum[EW] != acc_sum[EW-1]) ?
                     (acc_sum[EW] ? signed'(EMIN) : signed'(EMAX)) : acc_sum[EW-1:0];

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (count_reg >= hdru_pkg::MIN_LAST_POS) begin
                        state_next = ST_GAIN_GO;
                    end else if (last_now) begin
                        state_next = ST_SUM_LAST;
                    end
                end
            end
            ST_GAIN_GO: state_next = ST_GAIN_WAIT;
            ST_GAIN_WAIT: begin
                if (mul_stat.done) begin
                    state_next = at_left_reg ? ST_LEFT_GO : ST_OUT_UPD;
                end
            end
            ST_LEFT_GO: state_next = ST_LEFT_WAIT;
            ST_LEFT_WAIT: begin
                if (mul_stat.done) begin
                    state_next = ST_OUT_LEFT;
                end
            end
            ST_OUT_LEFT: begin
                if (out_free) begin
                    state_next = ST_OUT_UPD;
                end
            end
            ST_OUT_UPD: begin
                if (out_free) begin
                    state_next = last_reg ? ST_SUM_LAST : ST_IDLE;
                end
            end
            ST_SUM_LAST:  state_next = ST_ENERGY_GO;
            ST_ENERGY_GO: state_next = ST_ENERGY_WAIT;
            ST_ENERGY_WAIT: begin
                if (mul_stat.done) begin
                    state_next = ST_OUT_LAST;
                end
            end
            ST_OUT_LAST: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign load_out = out_free && ((state_reg == ST_OUT_LEFT) || (state_reg == ST_OUT_UPD) ||
                                   (state_reg == ST_OUT_LAST));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            energy_sum_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg <= last_now ? '0 : count_reg + 1'b1;
            end
            // the row's final beat restarts the sum for the next row
            if ((state_reg == ST_OUT_LAST) && out_free) begin
                energy_sum_reg <= '0;
            end else if (acc_en) begin
                energy_sum_reg <= acc_sat;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath and result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            lap_reg     <= lap_now;
            idx_reg     <= count_reg;
            last_reg    <= last_now;
            at_left_reg <= (count_reg == hdru_pkg::MIN_LAST_POS);
        end
        if ((state_reg == ST_GAIN_WAIT) && mul_stat.done) begin
            upd_reg <= upd_next;
        end
        if ((state_reg == ST_LEFT_WAIT) && mul_stat.done) begin
            left_reg <= left_next;
        end
        if ((state_reg == ST_ENERGY_WAIT) && mul_stat.done) begin
            energy_reg <= energy_next;
        end
        if (load_out) begin
            case (state_reg)
                ST_OUT_LEFT: begin
                    out_value_reg  <= left_reg;
                    out_index_reg  <= '0;
                    out_last_reg   <= 1'b0;
                    out_energy_reg <= '0;
                end
                ST_OUT_UPD: begin
                    out_value_reg  <= upd_reg;
                    out_index_reg  <= idx_reg - 1'b1;
                    out_last_reg   <= 1'b0;
                    out_energy_reg <= '0;
                end
                default: begin
                    // right end passes the raw sample through
                    out_value_reg  <= cell_data[0];
                    out_index_reg  <= idx_reg;
                    out_last_reg   <= 1'b1;
                    out_energy_reg <= energy_reg;
                end
            endcase
        end
    end

    // result beat packing: new_value, point_index, row_energy from bit 0 up
    always_comb begin
        m_tdata = '0;
        m_tdata[VALUE_WIDTH-1:0]        = out_value_reg;
        m_tdata[VALUE_WIDTH +: IW]      = out_index_reg;
        m_tdata[VALUE_WIDTH + IW +: EW] = out_energy_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
`include "heat_diffusion_row_update_assert.svh"

    `HDRU_ASSERT_NOW(a_ready_mul_idle, s_tready, !mul_stat.busy, "input ready while multiplier busy")
    `HDRU_ASSERT_NOW(a_done_in_wait, mul_stat.done, (state_reg == ST_GAIN_WAIT) || (state_reg == ST_LEFT_WAIT) || (state_reg == ST_ENERGY_WAIT), "multiplier result with no consumer")
    `HDRU_ASSERT_NOW(a_sum_clear_at_row_start, (state_reg == ST_IDLE) && (count_reg == '0), energy_sum_reg == '0, "energy sum not cleared at row start")
    `HDRU_ASSERT_NEXT(a_last_beat_ends_row, (state_reg == ST_OUT_LAST) && out_free, m_tlast && (count_reg == '0), "row end beat without row restart")

endmodule

// ----- sim/tb_heat_diffusion_row_update.sv -----
`timescale 1ns / 1ps
// self-checking testbench for heat_diffusion_row_update (1d ftcs row stencil)
// depends on hdru_pkg and the rtl of the block; directed table, then random settings phases

module tb_heat_diffusion_row_update;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 24;      // worst item yields the left boundary and the energy, plus margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 260;

    // register indexes the block must ignore
    localparam logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] REG_PAST_LAST = 8'd4;
    localparam logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] REG_TOP       = 8'hFF;

    // saturation bounds of the new values and of the energy
    localparam longint VALUE_MAX  = 64'sd2147483647;
    localparam longint VALUE_MIN  = -64'sd2147483648;
    localparam longint ENERGY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ENERGY_MIN = -64'sh0000_8000_0000_0000;

    // m_tdata layout, lowest bit up: new_value, point_index, row_energy
    localparam int IDX_LO    = 32;
    localparam int ENERGY_LO = IDX_LO + hdru_pkg::INDEX_WIDTH;

    typedef struct packed {
        logic [31:0]                       value;
        logic [hdru_pkg::INDEX_WIDTH-1:0]  index;
        logic                              last;
        logic [hdru_pkg::ENERGY_WIDTH-1:0] energy;
    } row_point_t;

    typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_kind_t;

    typedef struct {
        step_kind_t                           kind;
        logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] index;
        logic [31:0]                          data;
        bit                                   typed;  // expected points come from known_points
    } directed_step_t;

    typedef enum int {PACE_FULL, PACE_SPARSE_IN, PACE_SLOW_OUT, PACE_LIGHT} pace_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // prev_value
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;            // new_value, point_index, row_energy
    logic        m_tlast;            // last_of_row
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [hdru_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    heat_diffusion_row_update uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // shadow of the block: registers, three sample window, row position, energy sum
    logic [hdru_pkg::GAIN_WIDTH-1:0]      gain_q  = hdru_pkg::RESET_DIFFUSION_GAIN;
    logic [hdru_pkg::GAIN_WIDTH-1:0]      scale_q = hdru_pkg::RESET_BOUNDARY_SCALE;
    logic [hdru_pkg::WIDTH_REG_WIDTH-1:0] width_q = hdru_pkg::RESET_CELL_WIDTH;
    logic [hdru_pkg::INDEX_WIDTH-1:0]     len_q   = hdru_pkg::RESET_ROW_LENGTH;
    longint      older_q = 0;
    longint      middle_q = 0;
    int unsigned row_pos_q = 0;
    longint      energy_sum_q = 0;

    row_point_t     pending_points[$];   // grid points still owed by the block
    row_point_t     known_points[$];     // hand-typed points for the directed table
    directed_step_t directed_steps[$];

    int sender_gap_pct = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;
    int beats_in       = 0;
    int beats_out      = 0;
    int rows_out       = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    // q0.16 product, rounded half away from zero
    function automatic longint mul_q16(input longint a, input logic [15:0] g);
        longint unsigned mag;
        longint unsigned r;
        mag = (a < 0) ? -a : a;
        r = (mag >> 16) * g + (((mag & 64'hFFFF) * g + 64'h8000) >> 16);
        return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    function automatic longint clamp_value(input longint x);
        if (x > VALUE_MAX) return VALUE_MAX;
        if (x < VALUE_MIN) return VALUE_MIN;
        return x;
    endfunction

    // running sum times cell width (q16.16), rounded, clamped to 48 bits
    function automatic logic [hdru_pkg::ENERGY_WIDTH-1:0] row_energy_of(input longint s,
                                                                        input logic [31:0] w);
        longint unsigned mag;
        longint unsigned r;
        longint          e;
        mag = (s < 0) ? -s : s;
        r = mag * w[31:16] + ((mag * w[15:0] + 64'h8000) >> 16);
        if (s < 0) e = (r > 64'h0000_8000_0000_0000) ? ENERGY_MIN : -$signed(r);
        else e = (r > 64'h0000_7FFF_FFFF_FFFF) ? ENERGY_MAX : $signed(r);
        return e[hdru_pkg::ENERGY_WIDTH-1:0];
    endfunction

    function automatic void owe_point(input longint v, input int unsigned idx,
                                      input bit last, input bit typed);
        row_point_t pt;
        longint     s;
        s = energy_sum_q + v;
        energy_sum_q = (s > ENERGY_MAX) ? ENERGY_MAX : (s < ENERGY_MIN) ? ENERGY_MIN : s;
        if (typed) begin
            pt = known_points.pop_front();
        end else begin
            pt.value  = v[31:0];
            pt.index  = idx[hdru_pkg::INDEX_WIDTH-1:0];
            pt.last   = last;
            pt.energy = last ? row_energy_of(energy_sum_q, width_q) : '0;
        end
        pending_points.push_back(pt);
    endfunction

    // one accepted sample of the old row: queue the new grid points it completes
    function automatic void advance_row(input logic [31:0] raw, input bit typed);
        longint      cur;
        longint      lap;
        longint      upd;
        int unsigned len;
        int unsigned pos;
        cur = longint'($signed(raw));
        len = 32'((len_q < hdru_pkg::MIN_ROW_LENGTH) ? hdru_pkg::MIN_ROW_LENGTH : len_q);
        pos = row_pos_q;
        if (pos >= 2) begin
            lap = cur - 2 * middle_q + older_q;
            upd = clamp_value(middle_q + mul_q16(lap, gain_q));
            // robin boundary on the left, from the first interior point
            if (pos == 2) owe_point(clamp_value(mul_q16(upd, scale_q)), 0, 1'b0, typed);
            owe_point(upd, pos - 1, 1'b0, typed);
        end
        // right end passes through and closes the row, also after a shortened length
        if (pos >= len - 1) begin
            owe_point(cur, pos, 1'b1, typed);
            row_pos_q    = 0;
            energy_sum_q = 0;
        end else begin
            row_pos_q = (pos + 1) & 16'hFFFF;
        end
        older_q  = middle_q;
        middle_q = cur;
    endfunction

    function automatic void add_write(input logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                      input logic [31:0] data);
        directed_steps.push_back('{STEP_WRITE, idx, data, 1'b0});
    endfunction

    function automatic void add_sample(input logic [31:0] data, input bit typed);
        directed_steps.push_back('{STEP_SAMPLE, '0, data, typed});
    endfunction

    function automatic void add_known(input logic [31:0] v, input int idx, input bit last,
                                      input logic [hdru_pkg::ENERGY_WIDTH-1:0] e);
        known_points.push_back('{v, idx[hdru_pkg::INDEX_WIDTH-1:0], last, e});
    endfunction

    function automatic logic [31:0] pick_sample();
        int small_v;
        small_v = int'($urandom_range(0, 2097152)) - 1048576;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 65536);
            3:       return 32'h8000_0000 + $urandom_range(0, 65536);
            4:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return small_v;
        endcase
    endfunction

    function automatic void set_pace(input pace_t pace);
        sender_gap_pct = (pace == PACE_SPARSE_IN) ? 88 : (pace == PACE_LIGHT) ? 8 : 0;
        sink_stall_pct = (pace == PACE_SLOW_OUT) ? 88 : (pace == PACE_LIGHT) ? 8 : 0;
    endfunction

    // keeps cfg_valid high on return so that back to back writes need no drop
    task automatic write_reg(input logic [hdru_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            hdru_pkg::REG_DIFFUSION_GAIN: gain_q  = val[15:0];
            hdru_pkg::REG_BOUNDARY_SCALE: scale_q = val[15:0];
            hdru_pkg::REG_CELL_WIDTH:     width_q = val;
            hdru_pkg::REG_ROW_LENGTH:     len_q   = val[15:0];
            default: ;          // beyond the last register, dropped by the block
        endcase
        reg_writes++;
    endtask

    // keeps s_tvalid high on return; it only drops for a gap or at the caller
    task automatic push_sample(input logic [31:0] v, input bit typed);
        if ($urandom_range(0, 99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < sender_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        advance_row(v, typed);
        beats_in++;
    endtask

    // sender already idle: let every owed point out, then cover beats that yield nothing
    task automatic wait_idle();
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side back-pressure
    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // compare every result beat with the oldest owed grid point
    always @(posedge aclk) begin : result_check
        row_point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result beat: new_value %h point_index %0d",
                       m_tdata[31:0], m_tdata[IDX_LO +: hdru_pkg::INDEX_WIDTH]);
                fail_count++;
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $error("new_value: expected %h, got %h", want.value, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[IDX_LO +: hdru_pkg::INDEX_WIDTH] !== want.index) begin
                    $error("point_index: expected %0d, got %0d", want.index,
                           m_tdata[IDX_LO +: hdru_pkg::INDEX_WIDTH]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_row: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tdata[ENERGY_LO +: hdru_pkg::ENERGY_WIDTH] !== want.energy) begin
                    $error("row_energy: expected %h, got %h", want.energy,
                           m_tdata[ENERGY_LO +: hdru_pkg::ENERGY_WIDTH]);
                    fail_count++;
                end
            end
            beats_out++;
            if (m_tlast) rows_out++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL heat_diffusion_row_update");
            $finish;
        end
    end

    initial begin
        directed_step_t step;
        step_kind_t     prev_kind;
        int             phase_num;
        int             n_beats;

        // reset settings, long row: positions 0 and 1 stay silent, position 2 gives
        // the left boundary and the first interior point
        add_sample(32'h0001_0000, 1'b0);
        add_sample(32'h0003_0000, 1'b0);
        add_sample(32'h0002_0000, 1'b0);
        // row shortened mid-row: position 3 is already past the new end
        add_write(hdru_pkg::REG_ROW_LENGTH, 32'd3);
        add_sample(32'hFFFF_0000, 1'b0);

        // no diffusion, zero boundary, unit cell; length below 3 acts as 3;
        // writes past the last register must change nothing
        add_write(hdru_pkg::REG_DIFFUSION_GAIN, 32'd0);
        add_write(hdru_pkg::REG_BOUNDARY_SCALE, 32'd0);
        add_write(hdru_pkg::REG_CELL_WIDTH, 32'h0001_0000);
        add_write(hdru_pkg::REG_ROW_LENGTH, 32'd2);
        add_write(REG_PAST_LAST, 32'hFFFF_FFFF);
        add_write(REG_TOP, 32'h0000_0000);
        add_sample(32'd5, 1'b0);
        add_sample(32'hFFFF_FFF9, 1'b0);
        add_sample(32'd100, 1'b1);
        add_known(32'd0, 0, 1'b0, '0);
        add_known(32'hFFFF_FFF9, 1, 1'b0, '0);
        add_known(32'd100, 2, 1'b1, 48'd93);
        // most negative sample, negative energy
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b1);
        add_known(32'd0, 0, 1'b0, '0);
        add_known(32'h8000_0000, 1, 1'b0, '0);
        add_known(32'hFFFF_FFFF, 2, 1'b1, 48'hFFFF_7FFF_FFFF);

        // gain of one half, largest scale and cell width: energy clamps, halves round outward
        add_write(hdru_pkg::REG_DIFFUSION_GAIN, 32'd32768);
        add_write(hdru_pkg::REG_BOUNDARY_SCALE, 32'd65535);
        add_write(hdru_pkg::REG_CELL_WIDTH, 32'hFFFF_FFFF);
        add_write(hdru_pkg::REG_ROW_LENGTH, 32'd3);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'd0, 1'b0);
        add_sample(32'd0, 1'b0);
        add_sample(32'd1, 1'b0);
        add_sample(32'd0, 1'b0);
        add_sample(32'd0, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h8000_0000, 1'b0);

        set_pace(PACE_FULL);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table; the block is idle after reset, so a write may come first
        prev_kind = STEP_WRITE;
        foreach (directed_steps[i]) begin
            step = directed_steps[i];
            if (step.kind == STEP_WRITE) begin
                if (prev_kind == STEP_SAMPLE) begin
                    s_tvalid <= 1'b0;
                    wait_idle();
                end
                write_reg(step.index, step.data);
            end else begin
                if (prev_kind == STEP_WRITE) cfg_valid <= 1'b0;
                push_sample(step.data, step.typed);
            end
            prev_kind = step.kind;
        end
        s_tvalid <= 1'b0;

        // random phases: each drains the block, picks new settings, then streams
        // a burst that often stops mid-row so the next length lands mid-row
        phase_num = 0;
        while (beats_in < directed_steps.size() + RANDOM_BEATS) begin
            wait_idle();
            set_pace(pace_t'(phase_num % 4));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(hdru_pkg::CFG_INDEX_WIDTH'($urandom_range(4, 255)), $urandom());
            end
            case ($urandom_range(0, 3))
                0:       write_reg(hdru_pkg::REG_DIFFUSION_GAIN, 32'd0);
                1:       write_reg(hdru_pkg::REG_DIFFUSION_GAIN, 32'd32768);
                default: write_reg(hdru_pkg::REG_DIFFUSION_GAIN, $urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(hdru_pkg::REG_BOUNDARY_SCALE, 32'd0);
                1:       write_reg(hdru_pkg::REG_BOUNDARY_SCALE, 32'd65535);
                default: write_reg(hdru_pkg::REG_BOUNDARY_SCALE, $urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(hdru_pkg::REG_CELL_WIDTH, 32'd0);
                1:       write_reg(hdru_pkg::REG_CELL_WIDTH, 32'hFFFF_FFFF);
                2:       write_reg(hdru_pkg::REG_CELL_WIDTH, 32'h0001_0000);
                default: write_reg(hdru_pkg::REG_CELL_WIDTH, $urandom());
            endcase
            // mostly short rows; a few degenerate, long or longest lengths
            case ($urandom_range(0, 9))
                0:       write_reg(hdru_pkg::REG_ROW_LENGTH, $urandom_range(0, 2));
                1:       write_reg(hdru_pkg::REG_ROW_LENGTH, 32'd65535);
                2:       write_reg(hdru_pkg::REG_ROW_LENGTH, $urandom_range(13, 60));
                default: write_reg(hdru_pkg::REG_ROW_LENGTH, $urandom_range(3, 12));
            endcase
            cfg_valid <= 1'b0;
            n_beats = $urandom_range(10, 40);
            repeat (n_beats) push_sample(pick_sample(), 1'b0);
            s_tvalid <= 1'b0;
            phase_num++;
        end

        wait_idle();
        $display("covered %0d input beats, %0d result beats in %0d closed rows", beats_in,
                 beats_out, rows_out);
        $display("over %0d register writes in %0d random phases of mixed pacing", reg_writes,
                 phase_num);
        if (fail_count == 0) begin
            $display("PASS heat_diffusion_row_update");
        end else begin
            $display("FAIL heat_diffusion_row_update");
        end
        $finish;
    end

endmodule
